// ----- design/tscr_pkg.sv -----
// ----------------------------------------------------------------------------
// tscr_pkg: shared constants for the tile slot cache remapper
// Operation codes, parameter defaults, entry masks and config register indices.
// ----------------------------------------------------------------------------
package tscr_pkg;
    localparam int MAX_SOURCES_DEF = 2048;
    localparam int MAX_SLOTS_DEF   = 1024;

    localparam logic [1:0] OP_REMAP    = 2'd0;
    localparam logic [1:0] OP_FRAME    = 2'd1;
    localparam logic [1:0] OP_ACTIVATE = 2'd2;

    localparam logic [15:0] ID_MASK   = 16'h0FFF;
    localparam logic [15:0] FLAG_MASK = 16'hF000;

    localparam logic CFG_NUM_TILES  = 1'b0;
    localparam logic CFG_VRAM_SLOTS = 1'b1;
endpackage

// ----- design/tile_slot_cache_remapper.sv -----
// ----------------------------------------------------------------------------
// tile_slot_cache_remapper: maps tilemap entries onto a pool of tile slots
// Clock replacement cache with forward/reverse maps and per-slot frame stamps.
// ----------------------------------------------------------------------------
// After reset and after every activate op the block sweeps its tables clear,
// one entry a cycle, taking no word meanwhile. A frame op that wraps the frame
// clock sweeps the stamps clear. A bypassed remap goes straight to the output
// register; a hit or a miss with a never-used slot passes through the lookup,
// decide and commit states; a miss that runs the clock hand reads each slot
// examined on the single read port of the slot table (at most vram_slots, at
// least one), then evicts the chosen slot unless it was free. The result sits
// in an output register; the next word is taken only once the receiver has
// the previous result or takes it in the same cycle.
module tile_slot_cache_remapper #(
    parameter int MAX_SOURCES = tscr_pkg::MAX_SOURCES_DEF,
    parameter int MAX_SLOTS   = tscr_pkg::MAX_SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [11:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_op,
    input  logic [15:0] i_entry,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_mapped_entry,
    output logic        o_upload_valid,
    output logic [10:0] o_upload_source,
    output logic [9:0]  o_upload_slot
);
    localparam int SAW = $clog2(MAX_SOURCES);
    localparam int LAW = $clog2(MAX_SLOTS);
    localparam int CLR_N = (MAX_SOURCES > MAX_SLOTS) ? MAX_SOURCES : MAX_SLOTS;
    localparam int SDW = $clog2(CLR_N) + 1;   // clearing counter
    localparam int TDW = 13;        // source id field in slot table
    localparam int RDW = TDW + 16;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_LOOK, S_DECIDE, S_SCAN_RD, S_SCAN_CHK,
        S_EVICT, S_COMMIT, S_STAMP_CLR, S_OUT
    } t_state;

    t_state        r_state;
    logic [11:0]   r_num_tiles;
    logic [10:0]   r_vram_slots;
    logic [SDW-1:0] r_clr;
    logic          r_active;
    logic [15:0]   r_frame;
    logic [11:0]   r_unused;
    logic [11:0]   r_hand;
    logic [11:0]   r_scanned;
    logic [15:0]   r_entry;
    logic [11:0]   r_src;
    logic [11:0]   r_slot;
    logic          r_miss;
    logic          r_ovalid;
    logic [15:0]   r_omap;
    logic          r_oup;
    logic [10:0]   r_osrc;
    logic [9:0]    r_oslot;

    logic [12:0] eff_tiles;
    logic [11:0] eff_slots;
    assign eff_tiles = ({1'b0, r_num_tiles} > 13'(MAX_SOURCES)) ? 13'(MAX_SOURCES)
                                                               : {1'b0, r_num_tiles};
    assign eff_slots = ({1'b0, r_vram_slots} > 12'(MAX_SLOTS)) ? 12'(MAX_SLOTS)
                                                              : {1'b0, r_vram_slots};

    // forward map
    logic [SAW-1:0] f_raddr, f_waddr;
    logic [9:0]     f_rdata, f_wdata;
    logic           f_we;
    // slot table: {source id, stamp}
    logic [LAW-1:0] t_raddr, t_waddr;
    logic [RDW-1:0] t_rdata, t_wdata;
    logic           t_we;

    tscr_fwd_mem #(.DEPTH(MAX_SOURCES), .AW(SAW), .DW(10)) u_fwd (
        .i_clk(i_clk), .i_raddr(f_raddr), .o_rdata(f_rdata),
        .i_we(f_we), .i_waddr(f_waddr), .i_wdata(f_wdata)
    );
    tscr_stamp_mem #(.DEPTH(MAX_SLOTS), .AW(LAW), .DW(RDW)) u_slot (
        .i_clk(i_clk), .i_raddr(t_raddr), .o_rdata(t_rdata),
        .i_we(t_we), .i_waddr(t_waddr), .i_wdata(t_wdata)
    );

    logic [12:0] t_src;
    logic [15:0] t_stamp;
    assign t_src   = t_rdata[RDW-1:16];
    assign t_stamp = t_rdata[15:0];

    logic in_acc;
    assign o_stall = (r_state != S_IDLE) || (r_ovalid && i_stall);
    assign in_acc  = i_valid && !o_stall;

    logic [11:0] hand_nxt;
    assign hand_nxt = (r_hand + 12'd1 >= eff_slots) ? 12'd1 : r_hand + 12'd1;
    logic [11:0] hand_fix;
    assign hand_fix = (r_hand == 12'd0 || r_hand >= eff_slots) ? 12'd1 : r_hand;

    // memory port control
    always_comb begin
        f_raddr = r_src[SAW-1:0];
        f_we    = 1'b0;
        f_waddr = r_src[SAW-1:0];
        f_wdata = r_slot[9:0];
        t_raddr = r_hand[LAW-1:0];
        t_we    = 1'b0;
        t_waddr = r_slot[LAW-1:0];
        t_wdata = {13'(r_src), r_frame};
        if (in_acc) begin
            f_raddr = i_entry[SAW-1:0];
        end
        unique case (r_state)
            S_CLEAR: begin
                f_we    = (r_clr < SDW'(MAX_SOURCES));
                f_waddr = r_clr[SAW-1:0];
                f_wdata = '0;
                t_we    = (r_clr < SDW'(MAX_SLOTS));
                t_waddr = r_clr[LAW-1:0];
                t_wdata = '0;
            end
            S_STAMP_CLR: begin
                t_raddr = r_clr[LAW-1:0];
            end
            S_EVICT: begin
                // drop the old forward mapping
                f_we    = (t_src != 13'd0) && (t_src < 13'(MAX_SOURCES));
                f_waddr = t_src[SAW-1:0];
                f_wdata = '0;
            end
            S_COMMIT: begin
                f_we = r_miss;
                t_we = 1'b1;
            end
            default: ;
        endcase
        if (r_state == S_STAMP_CLR && r_clr != '0) begin
            // write back previous entry with stamp cleared
            t_we    = 1'b1;
            t_waddr = LAW'(r_clr - SDW'(1));
            t_wdata = {t_rdata[RDW-1:16], 16'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr        <= '0;
            r_num_tiles  <= '0;
            r_vram_slots <= '0;
            r_active     <= 1'b0;
            r_frame      <= 16'd1;
            r_unused     <= 12'd1;
            r_hand       <= 12'd1;
            r_ovalid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == tscr_pkg::CFG_NUM_TILES) r_num_tiles <= i_cfg_data;
                else r_vram_slots <= i_cfg_data[10:0];
            end
            if (r_ovalid && !i_stall && r_state != S_OUT) r_ovalid <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + SDW'(1);
                    if (r_clr == SDW'(CLR_N - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_entry <= i_entry;
                        r_src   <= i_entry[11:0];
                        r_miss  <= 1'b0;
                        if (i_op == tscr_pkg::OP_ACTIVATE) begin
                            r_frame  <= 16'd1;
                            r_unused <= 12'd1;
                            r_hand   <= 12'd1;
                            r_active <= (eff_tiles > {1'b0, eff_slots}) && (eff_tiles > 13'd1);
                            r_clr    <= '0;
                            r_state  <= S_CLEAR;
                        end else if (i_op == tscr_pkg::OP_FRAME) begin
                            if (r_active) begin
                                if (r_frame == 16'hFFFF) begin
                                    r_frame <= 16'd1;
                                    r_clr   <= '0;
                                    r_state <= S_STAMP_CLR;
                                end else begin
                                    r_frame <= r_frame + 16'd1;
                                end
                            end
                        end else if (i_op == tscr_pkg::OP_REMAP) begin
                            if (!r_active || i_entry[11:0] == 12'd0) begin
                                r_omap  <= i_entry;
                                r_oup   <= 1'b0;
                                r_osrc  <= '0;
                                r_oslot <= '0;
                                r_state <= S_OUT;
                            end else if ({1'b0, i_entry[11:0]} >= eff_tiles) begin
                                r_omap  <= i_entry & tscr_pkg::FLAG_MASK;
                                r_oup   <= 1'b0;
                                r_osrc  <= '0;
                                r_oslot <= '0;
                                r_state <= S_OUT;
                            end else begin
                                r_state <= S_LOOK;
                            end
                        end
                    end
                end
                S_LOOK: r_state <= S_DECIDE;
                S_DECIDE: begin
                    if (f_rdata != 10'd0 && {2'b0, f_rdata} < 12'(MAX_SLOTS)) begin
                        r_slot  <= {2'b0, f_rdata};
                        r_state <= S_COMMIT;
                    end else begin
                        r_miss <= 1'b1;
                        if (r_unused < eff_slots) begin
                            r_slot   <= r_unused;
                            r_unused <= r_unused + 12'd1;
                            r_state  <= S_COMMIT;
                        end else begin
                            r_hand    <= hand_fix;
                            r_scanned <= 12'd1;
                            r_state   <= S_SCAN_RD;
                        end
                    end
                end
                S_SCAN_RD: r_state <= S_SCAN_CHK;
                S_SCAN_CHK: begin
                    r_slot <= r_hand;
                    r_hand <= hand_nxt;
                    if (r_scanned >= eff_slots) begin
                        r_state <= S_EVICT; // forced
                    end else if (t_src == 13'd0) begin
                        r_state <= S_COMMIT;
                    end else if (t_stamp != r_frame) begin
                        r_state <= S_EVICT;
                    end else begin
                        r_scanned <= r_scanned + 12'd1;
                        r_state   <= S_SCAN_RD;
                    end
                end
                S_EVICT: r_state <= S_COMMIT;
                S_COMMIT: begin
                    r_omap  <= (16'(r_slot) & tscr_pkg::ID_MASK)
                               | (r_entry & tscr_pkg::FLAG_MASK);
                    r_oup   <= r_miss;
                    r_osrc  <= r_miss ? r_src[10:0] : 11'd0;
                    r_oslot <= r_miss ? r_slot[9:0] : 10'd0;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovalid || !i_stall) begin
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                S_STAMP_CLR: begin
                    r_clr <= r_clr + SDW'(1);
                    if (r_clr == SDW'(MAX_SLOTS)) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid         = r_ovalid;
    assign o_mapped_entry  = r_omap;
    assign o_upload_valid  = r_oup;
    assign o_upload_source = r_osrc;
    assign o_upload_slot   = r_oslot;
endmodule

// ----- design/tscr_stamp_mem.sv -----
// ----------------------------------------------------------------------------
// tscr_stamp_mem: per-slot table, slot -> (source id, frame stamp)
// Synchronous memory with a registered read, one read port and one write port.
// ----------------------------------------------------------------------------
module tscr_stamp_mem #(
    parameter int DEPTH = tscr_pkg::MAX_SLOTS_DEF,
    parameter int AW    = $clog2(DEPTH),
    parameter int DW    = 27
) (
    input  logic          i_clk,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata
);
    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- design/tscr_fwd_mem.sv -----
// ----------------------------------------------------------------------------
// tscr_fwd_mem: forward map, source id -> slot
// Synchronous memory with a registered read, one read port and one write port.
// ----------------------------------------------------------------------------
module tscr_fwd_mem #(
    parameter int DEPTH = tscr_pkg::MAX_SOURCES_DEF,
    parameter int AW    = $clog2(DEPTH),
    parameter int DW    = 10
) (
    input  logic          i_clk,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata
);
    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
